FILE: sv/dsm_pkg.sv
// Shared types, constants and helpers of the DTMF selective-call matcher.
// No dependencies; imported by every module of the block.
package dsm_pkg;

	localparam int WINDOW_DEPTH = 9;
	localparam int COUNT_MAX    = 15;
	localparam int COUNT_W      = $clog2(COUNT_MAX + 1);
	localparam int DIGIT_W      = 4;

	// Pattern spans, counted back from the newest digit
	localparam int CMD_SPAN   = 9;
	localparam int CALL_SPAN  = 7;
	localparam int CALL_TMPL  = 4;
	localparam int AB_SPAN    = 2;
	localparam int CMD_BASE   = WINDOW_DEPTH - CMD_SPAN;
	localparam int CALL_BASE  = WINDOW_DEPTH - CALL_SPAN;
	localparam int AB_BASE    = WINDOW_DEPTH - AB_SPAN;
	localparam int CALLER_POS = WINDOW_DEPTH - 3;

	localparam logic [DIGIT_W-1:0] DIGIT_A = 4'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_B = 4'd11;

	// Item kinds
	localparam logic [1:0] KIND_DIGIT     = 2'd0;
	localparam logic [1:0] KIND_CLEAR     = 2'd1;
	localparam logic [1:0] KIND_SET_STATE = 2'd2;

	// Reply codes
	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_AB   = 2'd1;
	localparam logic [1:0] REPLY_ID   = 2'd2;
	localparam logic [1:0] REPLY_UP   = 2'd3;

	// Call states
	localparam logic [1:0] CALL_IDLE     = 2'd0;
	localparam logic [1:0] CALL_OUT      = 2'd1;
	localparam logic [1:0] CALL_RECEIVED = 2'd2;

	// Decode-response modes
	localparam logic [1:0] RESP_NONE  = 2'd0;
	localparam logic [1:0] RESP_RING  = 2'd1;
	localparam logic [1:0] RESP_REPLY = 2'd2;
	localparam logic [1:0] RESP_BOTH  = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ID      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KILL_CMD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REVIVE_CMD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PERMIT_KILL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_MODE   = 3'd6;

	typedef struct packed {
		logic [11:0] own_id;
		logic [3:0]  separator;
		logic [3:0]  group;
		logic [19:0] kill_cmd;
		logic [19:0] revive_cmd;
		logic        permit_kill;
		logic [1:0]  response_mode;
	} dsm_cfg_t;

	// Expected digits seen by one cell, one per pattern
	typedef struct packed {
		logic [3:0] kill;
		logic [3:0] revive;
		logic [3:0] call;
		logic [3:0] ab;
	} dsm_tmpl_t;

	// Per-cell compare outcome; ok means equal or wildcard
	typedef struct packed {
		logic kill_ok;
		logic revive_ok;
		logic call_ok;
		logic call_wild;
		logic ab_ok;
	} dsm_cmp_t;

	// Digit k of ID + separator + 5-digit code
	function automatic logic [3:0] dsm_cmd_digit(input int k, input logic [11:0] id,
			input logic [3:0] sep, input logic [19:0] code);
		logic [3:0] d;
		case (k)
			0: d = id[11:8];
			1: d = id[7:4];
			2: d = id[3:0];
			3: d = sep;
			4: d = code[19:16];
			5: d = code[15:12];
			6: d = code[11:8];
			7: d = code[7:4];
			8: d = code[3:0];
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

FILE: sv/dtmf_selcall_matcher.sv
// DTMF selective-call matcher, top level. The result is valid in the
// cycle after item accept. One item per cycle when not stalled; the
// window cells, count, kill flag and call state all update in the accept
// cycle. Result sits in an output register; a new item is taken whenever
// that register is empty or its result is taken in the same cycle.
// Reset: window, count, kill flag, call state and config go to defaults.
module dtmf_selcall_matcher import dsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            kind,
	input  logic [3:0]            digit,
	input  logic [1:0]            new_call_state,
	input  logic                  suppress,
	input  logic                  decode_enable,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [1:0]            reply,
	output logic                  tx_success,
	output logic                  killed,
	output logic [1:0]            call_state,
	output logic                  ring_start,
	output logic                  group_hit,
	output logic [11:0]           caller_id,
	output logic [11:0]           callee_id,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dsm_cfg_t cfg;

	logic [DIGIT_W-1:0] win_q   [WINDOW_DEPTH];
	logic [DIGIT_W-1:0] win_nxt [WINDOW_DEPTH];
	dsm_cmp_t           cmp     [WINDOW_DEPTH];

	logic [WINDOW_DEPTH-1:0] kill_v, revive_v, call_v, wild_v, ab_v;
	logic kill_m, revive_m, call_m, ab_m;

	logic               accept, shift, clear;
	logic [COUNT_W-1:0] count_q, count_n, count_inc;
	logic               killed_flag_q, killed_n;
	logic [1:0]         call_status_q, call_n;

	logic [1:0]  reply_n;
	logic        tx_n, ring_n, ghit_n;
	logic [11:0] caller_n, callee_n;

	logic        result_valid_q;
	logic [1:0]  reply_q, call_state_q;
	logic        tx_success_q, killed_q, ring_start_q, group_hit_q;
	logic [11:0] caller_id_q, callee_id_q;

	dsm_cfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign item_stall = result_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;
	assign shift      = accept && (kind == KIND_DIGIT);
	assign clear      = accept && (kind == KIND_CLEAR);

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		localparam int CMD_K  = i - CMD_BASE;
		localparam int CALL_K = i - CALL_BASE;
		localparam int AB_K   = i - AB_BASE;
		localparam bit CALL_IN = (CALL_K >= 0) && (CALL_K < CALL_TMPL);

		dsm_tmpl_t tmpl;

		assign tmpl.kill   = dsm_cmd_digit(CMD_K, cfg.own_id, cfg.separator, cfg.kill_cmd);
		assign tmpl.revive = dsm_cmd_digit(CMD_K, cfg.own_id, cfg.separator,
			cfg.revive_cmd);
		assign tmpl.call   = dsm_cmd_digit(CALL_K, cfg.own_id, cfg.separator, 20'd0);
		assign tmpl.ab     = (AB_K == 0) ? DIGIT_A : DIGIT_B;

		if (i == WINDOW_DEPTH - 1) begin : g_head
			assign win_nxt[i] = digit;
		end else begin : g_body
			assign win_nxt[i] = win_q[i+1];
		end

		dsm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.clear  (clear),
			.din    (win_nxt[i]),
			.group  (cfg.group),
			.tmpl   (tmpl),
			.dout   (win_q[i]),
			.cmp    (cmp[i])
		);

		// cells outside a pattern's span never veto it
		assign kill_v[i]   = (CMD_K >= 0) ? cmp[i].kill_ok : 1'b1;
		assign revive_v[i] = (CMD_K >= 0) ? cmp[i].revive_ok : 1'b1;
		assign call_v[i]   = CALL_IN ? cmp[i].call_ok : 1'b1;
		assign wild_v[i]   = CALL_IN ? cmp[i].call_wild : 1'b0;
		assign ab_v[i]     = (AB_K >= 0) ? cmp[i].ab_ok : 1'b1;
	end

	assign kill_m   = &kill_v;
	assign revive_m = &revive_v;
	assign call_m   = &call_v;
	assign ab_m     = &ab_v;

	assign count_inc = (count_q < COUNT_W'(COUNT_MAX)) ? count_q + 1'b1 : count_q;

	always_comb begin
		count_n  = count_q;
		killed_n = killed_flag_q;
		call_n   = call_status_q;
		reply_n  = REPLY_NONE;
		tx_n     = 1'b0;
		ring_n   = 1'b0;
		ghit_n   = 1'b0;
		caller_n = '0;
		callee_n = '0;
		case (kind)
			KIND_CLEAR: begin
				count_n = '0;
			end
			KIND_SET_STATE: begin
				if (new_call_state == CALL_IDLE || new_call_state == CALL_OUT
						|| new_call_state == CALL_RECEIVED) begin
					call_n = new_call_state;
				end
			end
			KIND_DIGIT: begin
				count_n = count_inc;
				if (suppress || (!decode_enable && !killed_flag_q)) begin
					// digit stored, no evaluation
				end else if (count_inc >= COUNT_W'(CMD_SPAN)) begin
					if (kill_m) begin
						if (cfg.permit_kill) begin
							killed_n = 1'b1;
							reply_n  = REPLY_AB;
						end else begin
							reply_n  = REPLY_UP;
						end
					end else if (revive_m) begin
						killed_n = 1'b0;
						reply_n  = REPLY_AB;
					end
					call_n = CALL_IDLE;
				end else if (count_inc >= COUNT_W'(AB_SPAN) && ab_m) begin
					tx_n = 1'b1;
				end else if (!killed_flag_q && call_status_q == CALL_IDLE
						&& count_inc >= COUNT_W'(CALL_SPAN) && call_m) begin
					call_n   = CALL_RECEIVED;
					callee_n = {win_nxt[CALL_BASE], win_nxt[CALL_BASE+1],
						win_nxt[CALL_BASE+2]};
					caller_n = {win_nxt[CALLER_POS], win_nxt[CALLER_POS+1],
						win_nxt[CALLER_POS+2]};
					case (cfg.response_mode)
						RESP_BOTH: begin
							ring_n  = 1'b1;
							reply_n = REPLY_ID;
						end
						RESP_REPLY: reply_n = REPLY_ID;
						RESP_RING:  ring_n  = 1'b1;
						default:    reply_n = REPLY_UP;
					endcase
					if (|wild_v) begin
						reply_n = REPLY_UP;
						ghit_n  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			killed_flag_q  <= 1'b0;
			call_status_q  <= CALL_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q        <= count_n;
				killed_flag_q  <= killed_n;
				call_status_q  <= call_n;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reply_q      <= reply_n;
			tx_success_q <= tx_n;
			killed_q     <= killed_n;
			call_state_q <= call_n;
			ring_start_q <= ring_n;
			group_hit_q  <= ghit_n;
			caller_id_q  <= caller_n;
			callee_id_q  <= callee_n;
		end
	end

	assign result_valid = result_valid_q;
	assign reply        = reply_q;
	assign tx_success   = tx_success_q;
	assign killed       = killed_q;
	assign call_state   = call_state_q;
	assign ring_start   = ring_start_q;
	assign group_hit    = group_hit_q;
	assign caller_id    = caller_id_q;
	assign callee_id    = callee_id_q;

endmodule

FILE: sv/dsm_cfg_regs.sv
// Configuration register file of the selective-call matcher.
// Depends on dsm_pkg for register indexes and the config struct.
module dsm_cfg_regs import dsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output dsm_cfg_t              cfg
);

	dsm_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id        <= 12'h123;
			cfg_q.separator     <= 4'd14;
			cfg_q.group         <= 4'd15;
			cfg_q.kill_cmd      <= '0;
			cfg_q.revive_cmd    <= '0;
			cfg_q.permit_kill   <= 1'b0;
			cfg_q.response_mode <= RESP_NONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OWN_ID:      cfg_q.own_id        <= cfg_data[11:0];
				REG_SEPARATOR:   cfg_q.separator     <= cfg_data[3:0];
				REG_GROUP:       cfg_q.group         <= cfg_data[3:0];
				REG_KILL_CMD:    cfg_q.kill_cmd      <= cfg_data[19:0];
				REG_REVIVE_CMD:  cfg_q.revive_cmd    <= cfg_data[19:0];
				REG_PERMIT_KILL: cfg_q.permit_kill   <= cfg_data[0];
				REG_RESP_MODE:   cfg_q.response_mode <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/dsm_cell.sv
// One window cell: holds a digit, passes it to the older neighbor on shift,
// and compares the digit it is about to take against its expected digits.
// Depends on dsm_pkg.
module dsm_cell import dsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  logic               clear,
	input  logic [DIGIT_W-1:0] din,
	input  logic [DIGIT_W-1:0] group,
	input  dsm_tmpl_t          tmpl,
	output logic [DIGIT_W-1:0] dout,
	output dsm_cmp_t           cmp
);

	logic [DIGIT_W-1:0] digit_q;
	logic               wild;
	logic               call_eq;

	assign dout    = digit_q;
	assign wild    = (din == group);
	assign call_eq = (din == tmpl.call);

	always_comb begin
		cmp.kill_ok   = (din == tmpl.kill) || wild;
		cmp.revive_ok = (din == tmpl.revive) || wild;
		cmp.call_ok   = call_eq || wild;
		cmp.call_wild = !call_eq && wild;
		cmp.ab_ok     = (din == tmpl.ab) || wild;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (clear) begin
			digit_q <= '0;
		end else if (shift) begin
			digit_q <= din;
		end
	end

endmodule

FILE: tb/dtmf_selcall_matcher_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for dtmf_selcall_matcher: directed digit strings, then random
// kill/revive/call/AB sequences over several register settings. Depends on dsm_pkg and dtmf_selcall_matcher.
import dsm_pkg::*;

typedef struct packed {
	logic [1:0] kind;
	logic [3:0] digit;
	logic [1:0] new_call_state;
	logic       suppress;
	logic       decode_enable;
} dtmf_item_t;

typedef struct packed {
	logic [1:0]  reply;
	logic        tx_success;
	logic        killed;
	logic [1:0]  call_state;
	logic        ring_start;
	logic        group_hit;
	logic [11:0] caller_id;
	logic [11:0] callee_id;
} selcall_result_t;

// Mirrors the matcher's registers and state, queues the result of each accepted item
class selcall_scoreboard;
	dsm_cfg_t           regs;
	logic [3:0]         recent [WINDOW_DEPTH];
	logic [COUNT_W-1:0] heard;
	logic               locked_out;
	logic [1:0]         call_phase;
	selcall_result_t    expected_q [$];
	int                 fail_count, checked, calls_taken, commands_hit, acks_seen;

	function new();
		regs.own_id        = 12'h123;
		regs.separator     = 4'd14;
		regs.group         = 4'd15;
		regs.kill_cmd      = '0;
		regs.revive_cmd    = '0;
		regs.permit_kill   = 1'b0;
		regs.response_mode = RESP_NONE;
		foreach (recent[i]) recent[i] = '0;
		heard      = '0;
		locked_out = 1'b0;
		call_phase = CALL_IDLE;
	endfunction

	function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_OWN_ID:      regs.own_id        = val[11:0];
			REG_SEPARATOR:   regs.separator     = val[3:0];
			REG_GROUP:       regs.group         = val[3:0];
			REG_KILL_CMD:    regs.kill_cmd      = val;
			REG_REVIVE_CMD:  regs.revive_cmd    = val;
			REG_PERMIT_KILL: regs.permit_kill   = val[0];
			REG_RESP_MODE:   regs.response_mode = val[1:0];
			default: ;
		endcase
	endfunction

	// digit k of own ID + separator + five-digit code
	function logic [3:0] cmd_digit(input int k, input logic [19:0] code);
		if (k < 3)
			return regs.own_id[11 - 4 * k -: 4];
		if (k == 3)
			return regs.separator;
		return code[19 - 4 * (k - 4) -: 4];
	endfunction

	function bit digit_fits(input logic [3:0] rx, input logic [3:0] want);
		return rx == want || rx == regs.group;
	endfunction

	function bit matches_code(input logic [19:0] code);
		for (int k = 0; k < CMD_SPAN; k++)
			if (!digit_fits(recent[CMD_BASE + k], cmd_digit(k, code)))
				return 1'b0;
		return 1'b1;
	endfunction

	function void take_digit(input dtmf_item_t it, inout selcall_result_t r);
		bit wild;
		wild = 1'b0;
		for (int i = 0; i < WINDOW_DEPTH - 1; i++)
			recent[i] = recent[i + 1];
		recent[WINDOW_DEPTH - 1] = it.digit;
		if (heard < COUNT_MAX)
			heard++;
		// digit is stored either way
		if (it.suppress || (!it.decode_enable && !locked_out))
			return;
		if (heard >= CMD_SPAN) begin
			if (matches_code(regs.kill_cmd)) begin
				commands_hit++;
				if (regs.permit_kill) begin
					locked_out = 1'b1;
					r.reply = REPLY_AB;
				end else begin
					r.reply = REPLY_UP;
				end
			end else if (matches_code(regs.revive_cmd)) begin
				commands_hit++;
				locked_out = 1'b0;
				r.reply = REPLY_AB;
			end
			call_phase = CALL_IDLE;
			return;
		end
		if (heard >= AB_SPAN && digit_fits(recent[AB_BASE], DIGIT_A)
				&& digit_fits(recent[AB_BASE + 1], DIGIT_B)) begin
			r.tx_success = 1'b1;
			acks_seen++;
			return;
		end
		if (locked_out || call_phase != CALL_IDLE || heard < CALL_SPAN)
			return;
		for (int k = 0; k < CALL_TMPL; k++) begin
			if (recent[CALL_BASE + k] != cmd_digit(k, '0)) begin
				if (recent[CALL_BASE + k] != regs.group)
					return;
				wild = 1'b1;
			end
		end
		calls_taken++;
		call_phase = CALL_RECEIVED;
		r.callee_id = {recent[CALL_BASE], recent[CALL_BASE + 1], recent[CALL_BASE + 2]};
		r.caller_id = {recent[CALLER_POS], recent[CALLER_POS + 1], recent[CALLER_POS + 2]};
		case (regs.response_mode)
			RESP_BOTH: begin
				r.ring_start = 1'b1;
				r.reply = REPLY_ID;
			end
			RESP_REPLY: r.reply = REPLY_ID;
			RESP_RING: r.ring_start = 1'b1;
			default: r.reply = REPLY_UP;
		endcase
		// wildcard hit overrides the response mode
		if (wild) begin
			r.reply = REPLY_UP;
			r.group_hit = 1'b1;
		end
	endfunction

	function void note_item(input dtmf_item_t it);
		selcall_result_t r;
		r = '0;
		case (it.kind)
			KIND_CLEAR: begin
				foreach (recent[i]) recent[i] = '0;
				heard = '0;
			end
			KIND_SET_STATE: if (it.new_call_state <= CALL_RECEIVED) call_phase = it.new_call_state;
			KIND_DIGIT: take_digit(it, r);
			default: ;
		endcase
		r.killed = locked_out;
		r.call_state = call_phase;
		expected_q.push_back(r);
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	task report(input string msg);
		if (fail_count < 40)
			$display("ERROR at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task compare_field(input string name, input logic [11:0] got, input logic [11:0] want);
		if (got !== want)
			report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
	endtask

	task check_result(input selcall_result_t got);
		selcall_result_t want;
		if (expected_q.size() == 0) begin
			report("result arrived with nothing expected");
			return;
		end
		want = expected_q.pop_front();
		compare_field("reply", 12'(got.reply), 12'(want.reply));
		compare_field("tx_success", 12'(got.tx_success), 12'(want.tx_success));
		compare_field("killed", 12'(got.killed), 12'(want.killed));
		compare_field("call_state", 12'(got.call_state), 12'(want.call_state));
		compare_field("ring_start", 12'(got.ring_start), 12'(want.ring_start));
		compare_field("group_hit", 12'(got.group_hit), 12'(want.group_hit));
		compare_field("caller_id", got.caller_id, want.caller_id);
		compare_field("callee_id", got.callee_id, want.callee_id);
		checked++;
	endtask
endclass

module dtmf_selcall_matcher_test;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] CALL_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_ITEMS = 135;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] kind = KIND_DIGIT;
	logic [3:0] digit = '0;
	logic [1:0] new_call_state = CALL_IDLE;
	logic suppress = 1'b0;
	logic decode_enable = 1'b1;
	logic result_valid;
	logic [1:0] reply;
	logic tx_success, killed, ring_start, group_hit;
	logic [1:0] call_state;
	logic [11:0] caller_id, callee_id;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic rand_stall = 1'b0;
	logic hold_stall = 1'b0;
	wire result_stall = rand_stall | hold_stall;

	bit idle_on = 1'b1;
	bit noise_on = 1'b0;
	bit hold_go = 1'b0;
	int items_sent, settings_used;
	logic [3:0] pat [9];

	selcall_scoreboard sb = new();

	dtmf_selcall_matcher uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.kind(kind), .digit(digit), .new_call_state(new_call_state),
		.suppress(suppress), .decode_enable(decode_enable),
		.result_valid(result_valid), .result_stall(result_stall),
		.reply(reply), .tx_success(tx_success), .killed(killed), .call_state(call_state),
		.ring_start(ring_start), .group_hit(group_hit),
		.caller_id(caller_id), .callee_id(callee_id),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result({reply, tx_success, killed, call_state, ring_start, group_hit,
				caller_id, callee_id});
	end

	// receiver: random stall before each result
	initial begin
		int wait_cycles;
		forever begin
			wait_cycles = idle_on ? $urandom_range(0, 13) : 0;
			if (wait_cycles > 0) begin
				rand_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			rand_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid === 1'b1 && !result_stall));
		end
	end

	// one long receiver hold-off so the block backs up into its input
	initial begin
		wait (hold_go);
		hold_stall <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_stall <= 1'b0;
	end

	task automatic send_item(input logic [1:0] k, input logic [3:0] d, input logic [1:0] ncs,
			input logic sup, input logic en);
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind <= k;
		digit <= d;
		new_call_state <= ncs;
		suppress <= sup;
		decode_enable <= en;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		sb.note_item({k, d, ncs, sup, en});
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	task automatic send_digit(input logic [3:0] d);
		logic sup, en;
		sup = noise_on && $urandom_range(0, 11) == 0;
		en = !(noise_on && $urandom_range(0, 11) == 0);
		send_item(KIND_DIGIT, d, noise_on ? 2'($urandom) : CALL_IDLE, sup, en);
	endtask

	// sends pat[0..n-1], now and then with a wildcard or a wrong digit
	task automatic send_pattern(input int n);
		int k;
		if ($urandom_range(0, 3) == 0)
			pat[$urandom_range(0, n - 1)] = sb.regs.group;
		if ($urandom_range(0, 7) == 0)
			pat[$urandom_range(0, n - 1)] = 4'($urandom);
		for (k = 0; k < n; k++)
			send_digit(pat[k]);
	endtask

	task automatic send_sequence();
		int pick, k;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2: begin
				for (k = 0; k < 9; k++)
					pat[k] = sb.cmd_digit(k, pick == 2 ? sb.regs.revive_cmd : sb.regs.kill_cmd);
				repeat ($urandom_range(0, 2)) send_digit(4'($urandom));
				send_pattern(9);
			end
			3, 4: begin
				if ($urandom_range(0, 3) != 0)
					send_item(KIND_SET_STATE, 4'($urandom), CALL_IDLE, 1'($urandom), 1'($urandom));
				send_item(KIND_CLEAR, 4'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
				// a leading digit gives a count of 8 at the match
				if ($urandom_range(0, 2) == 0)
					send_digit(4'($urandom));
				for (k = 0; k < 4; k++)
					pat[k] = sb.cmd_digit(k, '0);
				for (k = 4; k < 7; k++)
					pat[k] = 4'($urandom);
				send_pattern(7);
			end
			5: begin
				pat[0] = DIGIT_A;
				pat[1] = DIGIT_B;
				send_pattern(2);
			end
			6, 7: repeat ($urandom_range(1, 5))
				send_item(2'($urandom), 4'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
			8: send_item(KIND_SET_STATE, 4'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
			default: send_item(KIND_CLEAR, 4'($urandom), 2'($urandom), 1'($urandom), 1'($urandom));
		endcase
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_settings(input dsm_cfg_t s);
		write_reg(REG_OWN_ID, CFG_DATA_W'(s.own_id));
		write_reg(REG_SEPARATOR, CFG_DATA_W'(s.separator));
		write_reg(REG_GROUP, CFG_DATA_W'(s.group));
		write_reg(REG_KILL_CMD, s.kill_cmd);
		write_reg(REG_REVIVE_CMD, s.revive_cmd);
		write_reg(REG_PERMIT_KILL, CFG_DATA_W'(s.permit_kill));
		write_reg(REG_RESP_MODE, CFG_DATA_W'(s.response_mode));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic dsm_cfg_t pick_settings(input int phase);
		dsm_cfg_t s;
		s.own_id        = 12'($urandom);
		s.separator     = 4'($urandom);
		s.group         = 4'($urandom);
		s.kill_cmd      = 20'($urandom);
		s.revive_cmd    = 20'($urandom);
		s.permit_kill   = 1'($urandom);
		s.response_mode = 2'(phase);
		if (phase == 1) begin
			s.own_id = '0;
			s.separator = '0;
			s.group = '0;
			s.kill_cmd = '0;
			s.revive_cmd = '1;
			s.permit_kill = 1'b0;
		end else if (phase == 2) begin
			s.own_id = '1;
			s.separator = '1;
			s.group = '1;
			s.kill_cmd = '1;
			s.revive_cmd = '0;
			s.permit_kill = 1'b1;
		end
		return s;
	endfunction

	task automatic wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		int phase, phase_end, spin;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: own ID 123, separator star, group hash
		settings_used = 1;
		send_item(KIND_CLEAR, 4'd0, CALL_IDLE, 1'b0, 1'b1);
		send_digit(4'd1);
		send_digit(4'd2);
		send_digit(4'd3);
		send_digit(4'd14);
		send_digit(4'd5);
		send_digit(4'd6);
		send_digit(4'd7);
		send_item(KIND_SET_STATE, 4'd0, CALL_UNUSED, 1'b0, 1'b1);
		send_item(KIND_SET_STATE, 4'd0, CALL_OUT, 1'b0, 1'b1);
		send_item(KIND_UNUSED, 4'd15, CALL_IDLE, 1'b1, 1'b0);
		send_item(KIND_CLEAR, 4'd0, CALL_IDLE, 1'b0, 1'b1);
		send_digit(DIGIT_A);
		send_digit(DIGIT_B);
		// kill command with a wildcard in the last place, kill not permitted
		send_digit(4'd1);
		send_digit(4'd2);
		send_digit(4'd3);
		send_digit(4'd14);
		send_digit(4'd0);
		send_digit(4'd0);
		send_digit(4'd0);
		send_digit(4'd0);
		send_digit(4'd15);
		send_item(KIND_DIGIT, 4'd9, CALL_IDLE, 1'b1, 1'b1);
		send_item(KIND_DIGIT, 4'd8, CALL_IDLE, 1'b0, 1'b0);
		item_valid <= 1'b0;

		noise_on = 1'b1;
		for (phase = 1; phase <= 6; phase++) begin
			wait_idle();
			apply_settings(pick_settings(phase));
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				idle_on = ($urandom_range(0, 3) != 0);
				if (phase == 3 && !hold_go && items_sent + 100 > phase_end) begin
					hold_go = 1'b1;
					idle_on = 1'b0;
					repeat (12) send_digit(4'($urandom));
				end
				send_sequence();
			end
			item_valid <= 1'b0;
		end

		idle_on = 1'b1;
		for (spin = 0; spin < 5000 && sb.pending() != 0; spin++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("Sent %0d items under %0d register settings, compared %0d results",
			items_sent, settings_used, sb.checked);
		$display("Predicted %0d incoming calls, %0d kill/revive matches, %0d AB acks",
			sb.calls_taken, sb.commands_hit, sb.acks_seen);
		if (sb.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout: run did not finish in time");
		$display("Test completed with failures");
		$finish;
	end
endmodule

FILE: dtmf_selcall_matcher.f
sv/dsm_pkg.sv
sv/dsm_cfg_regs.sv
sv/dsm_cell.sv
sv/dtmf_selcall_matcher.sv
tb/dtmf_selcall_matcher_test.sv
